### rtl/core/fkvt_pkg.sv
// Package for the fixed key/value table: operation codes, channel word types,
// and store control struct. No dependencies.
package fkvt_pkg;

   localparam int unsigned KindBits  = 3;
   localparam int unsigned KeyBits   = 32;
   localparam int unsigned ValueBits = 32;
   localparam int unsigned CountBits = 5;

   typedef enum logic [KindBits-1:0] {
      KIND_ADD    = 3'd0,
      KIND_GET    = 3'd1,
      KIND_UPDATE = 3'd2,
      KIND_DELETE = 3'd3,
      KIND_ERASE  = 3'd4
   } kind_type;

   typedef struct packed {
      logic [KindBits-1:0]  kind;
      logic [KeyBits-1:0]   key;
      logic [ValueBits-1:0] value;
      logic                 insert_missing;
   } req_word_type;

   typedef struct packed {
      logic                 success;
      logic [ValueBits-1:0] read_value;
      logic [CountBits-1:0] entry_count;
   } rsp_word_type;

   typedef struct packed {
      logic wr_key;
      logic wr_value;
      logic set_used;
      logic clr_used;
      logic clr_all;
   } store_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_COMMIT
   } state_type;

endpackage

### rtl/core/fkvt_if.sv
// Valid/ready channel interfaces for request and response words.
// Depends on fkvt_pkg.
interface fkvt_req_if;
   logic                 valid;
   logic                 ready;
   fkvt_pkg::req_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

interface fkvt_rsp_if;
   logic                 valid;
   logic                 ready;
   fkvt_pkg::rsp_word_type data;

   modport source (output valid, output data, input ready);
   modport sink   (input valid, input data, output ready);
endinterface

### rtl/core/fixed_key_value_table_top.sv
// Fully associative key/value table with SLOTS slots. Each operation (add, get,
// update, delete) scans every slot, one per cycle, through a single memory read
// port and one key comparator; erase and unknown kinds skip the scan. A new
// request is accepted only once the previous one has committed. The response
// sits in an output register, so the next request is accepted while an earlier
// response waits; the write-back step stalls only while that register is still
// full. Keys and values of never-written slots are never reported, since only
// slots with their used flag set can match.
// Depends on fkvt_pkg, fkvt_if, fkvt_store and fkvt_ctrl.
module fixed_key_value_table_top #(
   parameter int unsigned SLOTS      = 16,
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 32
) (
   input logic          clock,
   input logic          reset,
   fkvt_req_if.sink     req_ch,
   fkvt_rsp_if.source   rsp_ch
);
   import fkvt_pkg::*;

   localparam int unsigned AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int unsigned CW = $clog2(SLOTS + 1);

   logic                  rsp_valid_ff, rsp_valid_in;
   rsp_word_type          rsp_word_ff, rsp_word_in;
   logic                  rsp_free;
   logic                  done;
   logic                  res_ok;
   logic [VALUE_BITS-1:0] res_value;
   logic [CW-1:0]         res_count;
   logic [AW-1:0]         rd_addr;
   logic [KEY_BITS-1:0]   rd_key;
   logic [VALUE_BITS-1:0] rd_value;
   logic                  rd_used;
   store_op_type          op;
   logic [AW-1:0]         wr_addr;
   logic [KEY_BITS-1:0]   wr_key;
   logic [VALUE_BITS-1:0] wr_value;

   logic [VALUE_BITS+ValueBits-1:0] value_ext;
   logic [CW+CountBits-1:0]         count_ext;

   fkvt_ctrl #(
      .SLOTS      (SLOTS),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .AW         (AW),
      .CW         (CW)
   ) u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_ch.valid),
      .req_ready (req_ch.ready),
      .req_word  (req_ch.data),
      .rsp_free  (rsp_free),
      .done      (done),
      .res_ok    (res_ok),
      .res_value (res_value),
      .res_count (res_count),
      .rd_addr   (rd_addr),
      .rd_key    (rd_key),
      .rd_value  (rd_value),
      .rd_used   (rd_used),
      .op        (op),
      .wr_addr   (wr_addr),
      .wr_key    (wr_key),
      .wr_value  (wr_value)
   );

   fkvt_store #(
      .SLOTS      (SLOTS),
      .KEY_BITS   (KEY_BITS),
      .VALUE_BITS (VALUE_BITS),
      .AW         (AW)
   ) u_store (
      .clock    (clock),
      .reset    (reset),
      .rd_addr  (rd_addr),
      .rd_key   (rd_key),
      .rd_value (rd_value),
      .rd_used  (rd_used),
      .op       (op),
      .wr_addr  (wr_addr),
      .wr_key   (wr_key),
      .wr_value (wr_value)
   );

   assign rsp_free  = !rsp_valid_ff || rsp_ch.ready;
   assign value_ext = {{ValueBits{1'b0}}, res_value};
   assign count_ext = {{CountBits{1'b0}}, res_count};

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_word_in  = rsp_word_ff;
      if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
      if (done) begin
         rsp_valid_in            = 1'b1;
         rsp_word_in.success     = res_ok;
         rsp_word_in.read_value  = value_ext[ValueBits-1:0];
         rsp_word_in.entry_count = count_ext[CountBits-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      rsp_word_ff <= rsp_word_in;
   end

   assign rsp_ch.valid = rsp_valid_ff;
   assign rsp_ch.data  = rsp_word_ff;

endmodule

### rtl/core/fkvt_store.sv
// Slot storage: key and value memories with one registered read port and one
// write port, plus the per-slot used flags. Depends on fkvt_pkg.
module fkvt_store #(
   parameter int unsigned SLOTS      = 16,
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 32,
   parameter int unsigned AW         = 4
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic [AW-1:0]           rd_addr,
   output logic [KEY_BITS-1:0]     rd_key,
   output logic [VALUE_BITS-1:0]   rd_value,
   output logic                    rd_used,
   input  fkvt_pkg::store_op_type  op,
   input  logic [AW-1:0]           wr_addr,
   input  logic [KEY_BITS-1:0]     wr_key,
   input  logic [VALUE_BITS-1:0]   wr_value
);
   import fkvt_pkg::*;

   logic [KEY_BITS-1:0]   key_mem [SLOTS];
   logic [VALUE_BITS-1:0] value_mem [SLOTS];
   logic [SLOTS-1:0]      used_ff;
   logic [SLOTS-1:0]      used_in;
   logic [KEY_BITS-1:0]   key_rd_ff;
   logic [VALUE_BITS-1:0] value_rd_ff;
   logic                  used_rd_ff;

   always_ff @(posedge clock) begin
      if (op.wr_key) begin
         key_mem[wr_addr] <= wr_key;
      end
      key_rd_ff <= key_mem[rd_addr];
   end

   always_ff @(posedge clock) begin
      if (op.wr_value) begin
         value_mem[wr_addr] <= wr_value;
      end
      value_rd_ff <= value_mem[rd_addr];
   end

   always_comb begin
      used_in = used_ff;
      priority if (op.clr_all) begin
         used_in = '0;
      end else if (op.set_used) begin
         used_in[wr_addr] = 1'b1;
      end else if (op.clr_used) begin
         used_in[wr_addr] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         used_ff <= '0;
      end else begin
         used_ff <= used_in;
      end
      used_rd_ff <= used_ff[rd_addr];
   end

   assign rd_key   = key_rd_ff;
   assign rd_value = value_rd_ff;
   assign rd_used  = used_rd_ff;

endmodule

### rtl/core/fkvt_ctrl.sv
// Operation sequencer: for add, get, update and delete, walks all slots
// through one shared key comparator and tracks first match and first free
// slot; then commits the write-back. Depends on fkvt_pkg.
module fkvt_ctrl #(
   parameter int unsigned SLOTS      = 16,
   parameter int unsigned KEY_BITS   = 32,
   parameter int unsigned VALUE_BITS = 32,
   parameter int unsigned AW         = 4,
   parameter int unsigned CW         = 5
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_ready,
   input  fkvt_pkg::req_word_type  req_word,
   input  logic                    rsp_free,
   output logic                    done,
   output logic                    res_ok,
   output logic [VALUE_BITS-1:0]   res_value,
   output logic [CW-1:0]           res_count,
   output logic [AW-1:0]           rd_addr,
   input  logic [KEY_BITS-1:0]     rd_key,
   input  logic [VALUE_BITS-1:0]   rd_value,
   input  logic                    rd_used,
   output fkvt_pkg::store_op_type  op,
   output logic [AW-1:0]           wr_addr,
   output logic [KEY_BITS-1:0]     wr_key,
   output logic [VALUE_BITS-1:0]   wr_value
);
   import fkvt_pkg::*;

   localparam logic [AW-1:0] LastSlot = AW'(SLOTS - 1);

   state_type             state_ff, state_in;
   logic [KindBits-1:0]   kind_ff, kind_in;
   logic [KEY_BITS-1:0]   key_ff, key_in;
   logic [VALUE_BITS-1:0] value_ff, value_in;
   logic                  create_ff, create_in;
   logic [AW-1:0]         issue_ff, issue_in;
   logic                  pvld_ff, pvld_in;
   logic [AW-1:0]         pidx_ff, pidx_in;
   logic                  found_ff, found_in;
   logic [AW-1:0]         match_ff, match_in;
   logic [VALUE_BITS-1:0] mval_ff, mval_in;
   logic                  free_ok_ff, free_ok_in;
   logic [AW-1:0]         free_ff, free_in;
   logic [CW-1:0]         count_ff, count_in;

   logic [KEY_BITS+KeyBits-1:0]     key_ext;
   logic [VALUE_BITS+ValueBits-1:0] value_ext;
   logic                            hit;
   logic                            can_insert;
   logic                            ok;
   logic [VALUE_BITS-1:0]           rd;
   logic [CW-1:0]                   count_next;
   store_op_type                    op_c;
   logic [AW-1:0]                   addr_c;

   assign key_ext   = {{KEY_BITS{1'b0}}, req_word.key};
   assign value_ext = {{VALUE_BITS{1'b0}}, req_word.value};
   assign hit        = rd_used && (rd_key == key_ff);
   assign can_insert = !found_ff && free_ok_ff;

   // commit decision
   always_comb begin
      op_c       = '0;
      addr_c     = match_ff;
      ok         = 1'b0;
      rd         = '0;
      count_next = count_ff;
      unique case (kind_ff)
         KIND_ADD: begin
            if (can_insert) begin
               ok              = 1'b1;
               addr_c          = free_ff;
               op_c.wr_key     = 1'b1;
               op_c.wr_value   = 1'b1;
               op_c.set_used   = 1'b1;
               count_next      = count_ff + CW'(1);
            end
         end
         KIND_GET: begin
            if (found_ff) begin
               ok = 1'b1;
               rd = mval_ff;
            end
         end
         KIND_UPDATE: begin
            if (found_ff) begin
               ok            = 1'b1;
               op_c.wr_value = 1'b1;
            end else if (create_ff && can_insert) begin
               ok            = 1'b1;
               addr_c        = free_ff;
               op_c.wr_key   = 1'b1;
               op_c.wr_value = 1'b1;
               op_c.set_used = 1'b1;
               count_next    = count_ff + CW'(1);
            end
         end
         KIND_DELETE: begin
            if (found_ff) begin
               ok            = 1'b1;
               op_c.clr_used = 1'b1;
               count_next    = count_ff - CW'(1);
            end
         end
         KIND_ERASE: begin
            ok           = 1'b1;
            op_c.clr_all = 1'b1;
            count_next   = '0;
         end
         default: begin
         end
      endcase
   end

   always_comb begin
      state_in   = state_ff;
      kind_in    = kind_ff;
      key_in     = key_ff;
      value_in   = value_ff;
      create_in  = create_ff;
      issue_in   = issue_ff;
      pvld_in    = 1'b0;
      pidx_in    = issue_ff;
      found_in   = found_ff;
      match_in   = match_ff;
      mval_in    = mval_ff;
      free_ok_in = free_ok_ff;
      free_in    = free_ff;
      count_in   = count_ff;
      op         = '0;
      done       = 1'b0;

      if (pvld_ff) begin
         if (hit && !found_ff) begin
            found_in = 1'b1;
            match_in = pidx_ff;
            mval_in  = rd_value;
         end
         if (!rd_used && !free_ok_ff) begin
            free_ok_in = 1'b1;
            free_in    = pidx_ff;
         end
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               kind_in    = req_word.kind;
               key_in     = key_ext[KEY_BITS-1:0];
               value_in   = value_ext[VALUE_BITS-1:0];
               create_in  = req_word.insert_missing;
               found_in   = 1'b0;
               free_ok_in = 1'b0;
               issue_in   = '0;
               if (req_word.kind == KIND_ADD || req_word.kind == KIND_GET ||
                   req_word.kind == KIND_UPDATE || req_word.kind == KIND_DELETE) begin
                  state_in = ST_SCAN;
               end else begin
                  state_in = ST_COMMIT;
               end
            end
         end
         ST_SCAN: begin
            pvld_in = 1'b1;
            if (issue_ff == LastSlot) begin
               state_in = ST_DRAIN;
            end else begin
               issue_in = issue_ff + AW'(1);
            end
         end
         ST_DRAIN: begin
            state_in = ST_COMMIT;
         end
         ST_COMMIT: begin
            if (rsp_free) begin
               op       = op_c;
               count_in = count_next;
               done     = 1'b1;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         pvld_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         state_ff <= state_in;
         pvld_ff  <= pvld_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff    <= kind_in;
      key_ff     <= key_in;
      value_ff   <= value_in;
      create_ff  <= create_in;
      issue_ff   <= issue_in;
      pidx_ff    <= pidx_in;
      found_ff   <= found_in;
      match_ff   <= match_in;
      mval_ff    <= mval_in;
      free_ok_ff <= free_ok_in;
      free_ff    <= free_in;
   end

   assign req_ready = (state_ff == ST_IDLE);
   assign res_ok    = ok;
   assign res_value = rd;
   assign res_count = count_next;
   assign rd_addr   = issue_ff;
   assign wr_addr   = addr_c;
   assign wr_key    = key_ff;
   assign wr_value  = value_ff;

endmodule
